FILE: hw/rtl/pdsc_pkg.sv
// Shared types and constants for the PWM duty speed command decoder.
package pdsc_pkg;

	localparam int SPEED_W = 16;
	localparam int COUNT_W = 16;
	localparam int DUTY_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int SKIP_W = 2;

	localparam logic [SKIP_W-1:0] SKIP_CAPTURES = 2'd3;

	// dividend cc1*100 fits 23 bits, quotient 0..100 fits 7 bits
	localparam int DIVIDEND_W = COUNT_W + 7;
	localparam int DIV_STEPS = DUTY_W;
	localparam int DIVISOR_W = COUNT_W + DIV_STEPS - 1;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_STOP_BELOW = 7'd5;
	localparam logic [DUTY_W-1:0] DUTY_START_ABOVE = 7'd5;
	localparam logic [DUTY_W-1:0] GEAR1_LOW = 7'd5;
	localparam logic [DUTY_W-1:0] GEAR1_HIGH = 7'd15;
	localparam logic [DUTY_W-1:0] GEAR2_LOW = 7'd45;
	localparam logic [DUTY_W-1:0] GEAR2_HIGH = 7'd55;
	localparam logic [DUTY_W-1:0] GEAR3_LOW = 7'd85;

	localparam logic [SPEED_W-1:0] FULL_SPEED_RST = 16'd2450;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_START = 2'd2
	} state_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_GEAR  = 2'd0,
		REG_SECOND_GEAR = 2'd1,
		REG_THIRD_GEAR  = 2'd2,
		REG_FULL_SPEED  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} ctl_sts_t;

endpackage

FILE: hw/rtl/pdsc_item_if.sv
// Input item channel: valid/ready handshake with capture and overflow payload.
interface pdsc_item_if import pdsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               capture_event;
	logic               overflow_event;
	logic [COUNT_W-1:0] period_count;
	logic [COUNT_W-1:0] second_capture_count;
	logic               pin_high;
	logic               motor_stopped;

	modport source (
		output valid, capture_event, overflow_event, period_count,
			second_capture_count, pin_high, motor_stopped,
		input  ready
	);
	modport sink (
		input  valid, capture_event, overflow_event, period_count,
			second_capture_count, pin_high, motor_stopped,
		output ready
	);
endinterface

FILE: hw/rtl/pdsc_result_if.sv
// Result channel: valid/ready handshake with speed command payload.
interface pdsc_result_if import pdsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] target_speed;
	logic [1:0]         state_command;
	logic [DUTY_W-1:0]  duty_percent;
	logic               duty_valid;

	modport source (
		output valid, target_speed, state_command, duty_percent, duty_valid,
		input  ready
	);
	modport sink (
		input  valid, target_speed, state_command, duty_percent, duty_valid,
		output ready
	);
endinterface

FILE: hw/rtl/pdsc_datapath.sv
// Datapath: config registers, item latch, restoring divider, decode state, result register.
module pdsc_datapath import pdsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SPEED_W-1:0]   cfg_wdata,
	input  ctl_cmd_t             cmd,
	output ctl_sts_t             sts,
	pdsc_item_if.sink            item,
	pdsc_result_if.source        result
);

	logic [SPEED_W-1:0] first_gear_q, second_gear_q, third_gear_q, full_speed_q;

	logic               cap_q, ovf_q, pin_q, stopped_q;
	logic [COUNT_W-1:0] period_q, cc1_q;

	logic [SKIP_W-1:0]  capture_count_q;
	logic [SPEED_W-1:0] speed_target_q;
	logic [DUTY_W-1:0]  last_duty_q;

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DUTY_W-1:0]     quo_q;

	logic               out_valid_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic [1:0]         out_cmd_q;
	logic [DUTY_W-1:0]  out_duty_q;
	logic               out_dvalid_q;

	logic [DIVIDEND_W-1:0] dividend;
	logic [DIVIDEND_W-1:0] trial;
	logic                  fits;

	logic               capture_ok;
	logic [DUTY_W-1:0]  duty;
	state_cmd_t         cmd_n;
	logic               stopped_n;
	logic [SPEED_W-1:0] speed_n;
	logic [DUTY_W-1:0]  last_duty_n;
	logic [SKIP_W-1:0]  count_n;
	logic               dvalid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_gear_q  <= '0;
			second_gear_q <= '0;
			third_gear_q  <= '0;
			full_speed_q  <= FULL_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FIRST_GEAR:  first_gear_q  <= cfg_wdata;
				REG_SECOND_GEAR: second_gear_q <= cfg_wdata;
				REG_THIRD_GEAR:  third_gear_q  <= cfg_wdata;
				REG_FULL_SPEED:  full_speed_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cap_q     <= item.capture_event;
			ovf_q     <= item.overflow_event;
			period_q  <= item.period_count;
			cc1_q     <= item.second_capture_count;
			pin_q     <= item.pin_high;
			stopped_q <= item.motor_stopped;
		end
	end

	// cc1 * 100 as shifts and adds
	assign dividend = (DIVIDEND_W'(cc1_q) << 6) + (DIVIDEND_W'(cc1_q) << 5)
		+ (DIVIDEND_W'(cc1_q) << 2);
	assign trial = rem_q - DIVIDEND_W'(divisor_q);
	assign fits  = rem_q >= DIVIDEND_W'(divisor_q);

	// one quotient bit per step, most significant first
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q     <= dividend;
			divisor_q <= DIVISOR_W'(period_q) << (DIV_STEPS - 1);
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			if (fits) begin
				rem_q <= trial;
			end
			divisor_q <= divisor_q >> 1;
			quo_q     <= {quo_q[DUTY_W-2:0], fits};
		end
	end

	assign capture_ok = (period_q != '0) && (cc1_q <= period_q);
	assign duty = DUTY_FULL - quo_q;

	always_comb begin
		cmd_n       = CMD_NONE;
		stopped_n   = stopped_q;
		speed_n     = speed_target_q;
		last_duty_n = last_duty_q;
		count_n     = capture_count_q;
		dvalid_n    = 1'b0;
		if (cap_q) begin
			if (capture_count_q >= SKIP_CAPTURES) begin
				if (capture_ok) begin
					last_duty_n = duty;
					dvalid_n    = 1'b1;
					if (duty < GEAR1_HIGH && duty > GEAR1_LOW) begin
						speed_n = first_gear_q;
					end else if (duty > GEAR2_LOW && duty < GEAR2_HIGH) begin
						speed_n = second_gear_q;
					end else if (duty > GEAR3_LOW) begin
						speed_n = third_gear_q;
					end else if (duty < DUTY_STOP_BELOW) begin
						stopped_n = 1'b1;
						cmd_n     = CMD_STOP;
					end
					if (stopped_n && duty > DUTY_START_ABOVE) begin
						stopped_n = 1'b0;
						cmd_n     = CMD_START;
					end
				end
			end else begin
				count_n = capture_count_q + 1'b1;
			end
		end
		if (ovf_q) begin
			count_n = '0;
			if (!pin_q) begin
				cmd_n = CMD_STOP;
			end else begin
				speed_n = full_speed_q;
				if (stopped_n) begin
					cmd_n = CMD_START;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_count_q <= '0;
			speed_target_q  <= '0;
			last_duty_q     <= '0;
		end else if (cmd.commit) begin
			capture_count_q <= count_n;
			speed_target_q  <= speed_n;
			last_duty_q     <= last_duty_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_speed_q  <= speed_n;
			out_cmd_q    <= cmd_n;
			out_duty_q   <= last_duty_n;
			out_dvalid_q <= dvalid_n;
		end
	end

	assign sts.out_busy = out_valid_q && !result.ready;

	assign result.valid         = out_valid_q;
	assign result.target_speed  = out_speed_q;
	assign result.state_command = out_cmd_q;
	assign result.duty_percent  = out_duty_q;
	assign result.duty_valid    = out_dvalid_q;

endmodule

FILE: hw/rtl/pdsc_controller.sv
// Controller: sequences item latch, divider steps and commit to the result register.
module pdsc_controller import pdsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_COMMIT
	} ctl_state_t;

	ctl_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic              ready_q;
	logic              accept;

	assign accept   = in_valid && ready_q;
	assign in_ready = ready_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.div_init = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_COMMIT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					step_q  <= STEP_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_COMMIT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_COMMIT: begin
					// hold until the result register is free
					if (!sts.out_busy) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/pwm_duty_speed_command_decoder.sv
// Sequence from input transfer to result valid: divider setup, 7 divide steps, commit;
// one item at a time, so a new item is taken only once the previous one has been committed.
// The 7-step restoring divider forms cc1*100/period; the result
// register lets the next item enter while a finished result waits to be taken.
// Reset (arst_n low): gear speeds 0, full speed 2450, capture count, speed and duty cleared.
module pwm_duty_speed_command_decoder import pdsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SPEED_W-1:0]   cfg_wdata,
	pdsc_item_if.sink            item,
	pdsc_result_if.source        result
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	pdsc_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.result    (result)
	);

endmodule

FILE: bench/tb.sv
// Testbench for the PWM duty speed command decoder: directed and random items checked in order.
module tb import pdsc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_ITEMS    = 490;

	typedef struct {
		logic               capture_event;
		logic               overflow_event;
		logic [COUNT_W-1:0] period_count;
		logic [COUNT_W-1:0] second_capture_count;
		logic               pin_high;
		logic               motor_stopped;
	} pwm_item_t;

	typedef struct {
		logic [SPEED_W-1:0] target_speed;
		logic [1:0]         state_command;
		logic [DUTY_W-1:0]  duty_percent;
		logic               duty_valid;
	} speed_command_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_reg_t             cfg_index;
	logic [SPEED_W-1:0]   cfg_wdata;

	pdsc_item_if   item_ch ();
	pdsc_result_if result_ch ();

	pwm_duty_speed_command_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	// speed table and decoder state as the block should hold them
	logic [SPEED_W-1:0] gear1_speed, gear2_speed, gear3_speed, overflow_speed;
	logic [SKIP_W-1:0]  captures_seen;
	logic [SPEED_W-1:0] commanded_speed;
	logic [DUTY_W-1:0]  decoded_duty;

	pwm_item_t      item_backlog[$];
	speed_command_t expected_commands[$];
	pwm_item_t      next_item;

	int  items_queued;
	int  items_accepted;
	int  fail_count;
	int  idle_cycles;
	logic item_fire;

	int  burst_left;
	int  gap_left;
	int  hold_left;
	int  sink_mode;
	int  mode_left;
	int  sink_cycle;
	logic hold_request;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic speed_command_t decode_pwm_item(pwm_item_t it);
		speed_command_t r;
		logic           stopped;
		int unsigned    duty;
		stopped = it.motor_stopped;
		r.state_command = CMD_NONE;
		r.duty_valid = 1'b0;
		if (it.capture_event) begin
			if (captures_seen >= SKIP_CAPTURES) begin
				if (it.period_count != 0 && it.second_capture_count <= it.period_count) begin
					duty = 100 - (int'(it.second_capture_count) * 100) / int'(it.period_count);
					decoded_duty = duty[DUTY_W-1:0];
					r.duty_valid = 1'b1;
					if (duty < 15 && duty > 5)
						commanded_speed = gear1_speed;
					else if (duty > 45 && duty < 55)
						commanded_speed = gear2_speed;
					else if (duty > 85)
						commanded_speed = gear3_speed;
					else if (duty < 5) begin
						stopped = 1'b1;
						r.state_command = CMD_STOP;
					end
					if (stopped && duty > 5) begin
						stopped = 1'b0;
						r.state_command = CMD_START;
					end
				end
			end else begin
				captures_seen = captures_seen + 1'b1;
			end
		end
		if (it.overflow_event) begin
			captures_seen = '0;
			if (!it.pin_high) begin
				stopped = 1'b1;
				r.state_command = CMD_STOP;
			end else begin
				commanded_speed = overflow_speed;
				if (stopped)
					r.state_command = CMD_START;
			end
		end
		r.target_speed = commanded_speed;
		r.duty_percent = decoded_duty;
		return r;
	endfunction

	function automatic pwm_item_t make_item(logic cap, logic ovf, int unsigned period,
		int unsigned cc1, logic pin, logic stopped);
		pwm_item_t it;
		it.capture_event = cap;
		it.overflow_event = ovf;
		it.period_count = period[COUNT_W-1:0];
		it.second_capture_count = cc1[COUNT_W-1:0];
		it.pin_high = pin;
		it.motor_stopped = stopped;
		return it;
	endfunction

	// capture aimed at a band edge or a random duty, period of varied size
	function automatic pwm_item_t duty_capture();
		int unsigned per, aim, cc;
		case ($urandom_range(0, 3))
			0: per = $urandom_range(1, 255);
			1: per = $urandom_range(1, 65535);
			2: per = 65535 - $urandom_range(0, 15);
			default: per = 100 * $urandom_range(1, 655);
		endcase
		case ($urandom_range(0, 15))
			0: aim = 0;
			1: aim = 4;
			2: aim = 5;
			3: aim = 6;
			4: aim = 14;
			5: aim = 15;
			6: aim = 45;
			7: aim = 46;
			8: aim = 54;
			9: aim = 55;
			10: aim = 85;
			11: aim = 86;
			12: aim = 100;
			13: aim = 10;
			14: aim = 50;
			default: aim = $urandom_range(0, 100);
		endcase
		if ($urandom_range(0, 9) == 0)
			cc = $urandom_range(0, per);
		else begin
			cc = ((100 - aim) * per + $urandom_range(0, 99)) / 100;
			if (cc > per)
				cc = per;
		end
		return make_item(1'b1, 1'b0, per, cc, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	function automatic pwm_item_t noise_item();
		int unsigned per, cc;
		case ($urandom_range(0, 3))
			0: per = 0;
			1: per = $urandom_range(1, 64);
			default: per = $urandom_range(0, 65535);
		endcase
		if ($urandom_range(0, 1) == 0 && per < 65535)
			cc = per + $urandom_range(1, 65535 - per);
		else
			cc = $urandom_range(0, 65535);
		return make_item(1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0, per, cc,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic push_item(pwm_item_t it);
		item_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic write_speed_reg(cfg_reg_t idx, logic [SPEED_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_FIRST_GEAR:  gear1_speed = value;
			REG_SECOND_GEAR: gear2_speed = value;
			REG_THIRD_GEAR:  gear3_speed = value;
			REG_FULL_SPEED:  overflow_speed = value;
			default: ;
		endcase
	endtask

	task automatic load_speed_table(logic [SPEED_W-1:0] g1, logic [SPEED_W-1:0] g2,
		logic [SPEED_W-1:0] g3, logic [SPEED_W-1:0] full);
		write_speed_reg(REG_FIRST_GEAR, g1);
		write_speed_reg(REG_SECOND_GEAR, g2);
		write_speed_reg(REG_THIRD_GEAR, g3);
		write_speed_reg(REG_FULL_SPEED, full);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || expected_commands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly overflow, skipped captures, then duty captures; the rest noise
	task automatic fill_random_phase(int count);
		int added;
		int n;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 9) < 8) begin
				push_item(make_item(1'b0, 1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 3) != 0, 1'($urandom_range(0, 1))));
				repeat (3) push_item(make_item(1'b1, 1'b0, $urandom_range(0, 65535),
					$urandom_range(0, 65535), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
				n = $urandom_range(2, 30);
				repeat (n) push_item(duty_capture());
				added += 4 + n;
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) push_item(noise_item());
				added += n;
			end
		end
	endtask

	// sender: bursts of random length with random gaps
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || item_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (item_backlog.size() > 0) begin
				next_item = item_backlog.pop_front();
				item_ch.capture_event <= next_item.capture_event;
				item_ch.overflow_event <= next_item.overflow_event;
				item_ch.period_count <= next_item.period_count;
				item_ch.second_capture_count <= next_item.second_capture_count;
				item_ch.pin_high <= next_item.pin_high;
				item_ch.motor_stopped <= next_item.motor_stopped;
				item_ch.valid <= 1'b1;
				if (burst_left > 1)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern that switches mode now and then, plus one long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (mode_left == 0) begin
			sink_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end else
			mode_left--;
		sink_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			case (sink_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= (sink_cycle % 4 == 0);
				default: result_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// predict on every input transfer
	always @(posedge clk) begin : predict_commands
		pwm_item_t taken;
		item_fire <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			taken.capture_event = item_ch.capture_event;
			taken.overflow_event = item_ch.overflow_event;
			taken.period_count = item_ch.period_count;
			taken.second_capture_count = item_ch.second_capture_count;
			taken.pin_high = item_ch.pin_high;
			taken.motor_stopped = item_ch.motor_stopped;
			expected_commands.push_back(decode_pwm_item(taken));
			items_accepted++;
		end
	end

	always @(posedge clk) begin : check_commands
		speed_command_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.target_speed = result_ch.target_speed;
			got.state_command = result_ch.state_command;
			got.duty_percent = result_ch.duty_percent;
			got.duty_valid = result_ch.duty_valid;
			if (expected_commands.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: speed %0d cmd %0d duty %0d valid %0b",
						got.target_speed, got.state_command, got.duty_percent, got.duty_valid);
			end else begin
				want = expected_commands.pop_front();
				if (got.target_speed !== want.target_speed
					|| got.state_command !== want.state_command
					|| got.duty_percent !== want.duty_percent
					|| got.duty_valid !== want.duty_valid) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"mismatch at %0t: speed %0d/%0d cmd %0d/%0d ",
							"duty %0d/%0d valid %0b/%0b (expected/actual)"},
							$realtime, want.target_speed, got.target_speed,
							want.state_command, got.state_command,
							want.duty_percent, got.duty_percent,
							want.duty_valid, got.duty_valid);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FIRST_GEAR;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.capture_event = 1'b0;
		item_ch.overflow_event = 1'b0;
		item_ch.period_count = '0;
		item_ch.second_capture_count = '0;
		item_ch.pin_high = 1'b0;
		item_ch.motor_stopped = 1'b0;
		result_ch.ready = 1'b0;
		gear1_speed = '0;
		gear2_speed = '0;
		gear3_speed = '0;
		overflow_speed = FULL_SPEED_RST;
		captures_seen = '0;
		commanded_speed = '0;
		decoded_duty = '0;
		items_queued = 0;
		items_accepted = 0;
		fail_count = 0;
		idle_cycles = 0;
		item_fire = 1'b0;
		burst_left = 1;
		gap_left = 0;
		hold_left = 0;
		sink_mode = 0;
		mode_left = 0;
		sink_cycle = 0;
		hold_request = 1'b0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed part: gears set, full speed left at its reset value
		write_speed_reg(REG_FIRST_GEAR, 16'h1111);
		write_speed_reg(REG_SECOND_GEAR, 16'h2222);
		write_speed_reg(REG_THIRD_GEAR, 16'hFFFF);
		@(negedge clk);
		cfg_we <= 1'b0;

		push_item(make_item(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
		// first captures after reset only advance the skip count
		push_item(make_item(1'b1, 1'b0, 0, 5, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 10, 20, 1'b1, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 50, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 0, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 100, 100, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 95, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 100, 96, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 94, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 86, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 100, 85, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 100, 55, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 54, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 46, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 100, 45, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 15, 1'b0, 1'b0));
		push_item(make_item(1'b1, 1'b0, 100, 14, 1'b0, 1'b0));
		// zero period and a count past the period are both dropped
		push_item(make_item(1'b1, 1'b0, 0, 0, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 1000, 1001, 1'b0, 1'b1));
		push_item(make_item(1'b1, 1'b0, 65535, 65535, 1'b1, 1'b0));
		push_item(make_item(1'b1, 1'b0, 65535, 1, 1'b1, 1'b1));
		// capture stops the motor, then the overflow in the same item starts it
		push_item(make_item(1'b1, 1'b1, 100, 100, 1'b1, 1'b0));
		push_item(make_item(1'b0, 1'b1, 0, 0, 1'b0, 1'b0));
		push_item(make_item(1'b0, 1'b1, 0, 0, 1'b1, 1'b1));
		push_item(make_item(1'b1, 1'b1, 100, 0, 1'b1, 1'b0));
		wait_drained();

		load_speed_table(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		fill_random_phase(PHASE_ITEMS);
		hold_request = 1'b1;
		wait_drained();

		load_speed_table(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		fill_random_phase(PHASE_ITEMS);
		wait_drained();

		repeat (2) begin
			load_speed_table(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			fill_random_phase(PHASE_ITEMS);
			wait_drained();
		end

		if (expected_commands.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
